>>> rtl/iaig_pkg.sv
`default_nettype none
package iaig_pkg;

    localparam int DEPTH   = 64;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int POS_W   = 6;
    localparam int WORD_W  = 32;
    localparam int ECNT_W  = 7;
    // common width for position/count compares
    localparam int CMP_W   = (CNT_W > ECNT_W) ? CNT_W : ECNT_W;

    localparam logic [1:0] ACT_PUSH   = 2'd0;
    localparam logic [1:0] ACT_INSERT = 2'd1;
    localparam logic [1:0] ACT_GET    = 2'd2;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_BAD_INDEX = 2'd1;
    localparam logic [1:0] STAT_FULL      = 2'd2;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [WORD_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

endpackage
`default_nettype wire

>>> rtl/iaig_ram.sv
`default_nettype none
module iaig_ram #(
    parameter int WIDTH = 32,
    parameter int WORDS = 64
) (
    input  wire logic                       aclk,
    input  wire logic                       we,
    input  wire logic [$clog2(WORDS)-1:0]   waddr,
    input  wire logic [WIDTH-1:0]           wdata,
    input  wire logic [$clog2(WORDS)-1:0]   raddr,
    output logic      [WIDTH-1:0]           rdata
);

    logic [WIDTH-1:0] mem [WORDS];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

>>> rtl/iaig_ctrl.sv
`default_nettype none
module iaig_ctrl import iaig_pkg::*; (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic [1:0]               s_action,
    input  wire logic [POS_W-1:0]         s_position,
    input  wire logic signed [WORD_W-1:0] s_value,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic [1:0]                    m_status,
    output logic signed [WORD_W-1:0]      m_read_word,
    output logic [ECNT_W-1:0]             m_entry_count,
    output mem_req_t                      mem_req,
    input  wire logic [WORD_W-1:0]        mem_rdata
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_CHECK = 6'b000010,
        ST_SHIFT = 6'b000100,
        ST_INSW  = 6'b001000,
        ST_GETW  = 6'b010000,
        ST_FIN   = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [1:0]          act_reg;
    logic [POS_W-1:0]    pos_reg;
    logic [WORD_W-1:0]   val_reg;
    logic [ADDR_W-1:0]   k_reg, k_next;
    logic [1:0]          res_status_reg, res_status_next;
    logic [WORD_W-1:0]   res_word_reg, res_word_next;
    logic                m_valid_reg, m_valid_next;
    logic [1:0]          m_status_reg;
    logic [WORD_W-1:0]   m_word_reg;
    logic [ECNT_W-1:0]   m_count_reg;

    logic                in_fire;
    logic                out_load;
    logic [CMP_W-1:0]    pos_ext;
    logic [CMP_W-1:0]    count_ext;
    logic                bad_index;
    logic                full;
    logic [ADDR_W-1:0]   pos_addr;
    logic [ADDR_W-1:0]   k_dec;

    assign s_ready   = (state_reg == ST_IDLE);
    assign in_fire   = s_valid && s_ready;
    assign out_load  = (state_reg == ST_FIN) && (!m_valid_reg || m_ready);
    assign pos_ext   = CMP_W'(pos_reg);
    assign count_ext = CMP_W'(count_reg);
    assign bad_index = (pos_ext >= count_ext);
    assign full      = (count_ext == CMP_W'(DEPTH));
    assign pos_addr  = ADDR_W'(pos_reg);
    assign k_dec     = k_reg - ADDR_W'(1);

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        k_next          = k_reg;
        res_status_next = res_status_reg;
        res_word_next   = res_word_reg;
        m_valid_next    = m_valid_reg;
        mem_req.we      = 1'b0;
        mem_req.waddr   = k_reg;
        mem_req.wdata   = mem_rdata;
        mem_req.raddr   = pos_addr;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                res_status_next = STAT_OK;
                res_word_next   = '0;
                state_next      = ST_FIN;
                case (act_reg)
                    ACT_PUSH: begin
                        if (full) begin
                            res_status_next = STAT_FULL;
                        end else begin
                            mem_req.we    = 1'b1;
                            mem_req.waddr = ADDR_W'(count_reg);
                            mem_req.wdata = val_reg;
                            count_next    = count_reg + CNT_W'(1);
                            res_word_next = val_reg;
                        end
                    end
                    ACT_INSERT: begin
                        if (bad_index) begin
                            res_status_next = STAT_BAD_INDEX;
                        end else if (full) begin
                            res_status_next = STAT_FULL;
                        end else begin
                            // ripple entries up from the top, one per cycle
                            k_next        = ADDR_W'(count_reg);
                            mem_req.raddr = ADDR_W'(count_reg) - ADDR_W'(1);
                            state_next    = ST_SHIFT;
                        end
                    end
                    default: begin
                        if (bad_index) begin
                            res_status_next = STAT_BAD_INDEX;
                        end else begin
                            mem_req.raddr = pos_addr;
                            state_next    = ST_GETW;
                        end
                    end
                endcase
            end
            ST_SHIFT: begin
                // rdata holds entry k-1; next read is k-2, never the write address
                mem_req.we    = 1'b1;
                mem_req.waddr = k_reg;
                mem_req.wdata = mem_rdata;
                if (k_dec == pos_addr) begin
                    state_next = ST_INSW;
                end else begin
                    mem_req.raddr = k_reg - ADDR_W'(2);
                    k_next        = k_dec;
                end
            end
            ST_INSW: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = pos_addr;
                mem_req.wdata = val_reg;
                count_next    = count_reg + CNT_W'(1);
                res_word_next = val_reg;
                state_next    = ST_FIN;
            end
            ST_GETW: begin
                res_word_next = mem_rdata;
                state_next    = ST_FIN;
            end
            ST_FIN: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            act_reg <= s_action;
            pos_reg <= s_position;
            val_reg <= s_value;
        end
        k_reg          <= k_next;
        res_status_reg <= res_status_next;
        res_word_reg   <= res_word_next;
        if (out_load) begin
            m_status_reg <= res_status_reg;
            m_word_reg   <= res_word_reg;
            m_count_reg  <= ECNT_W'(count_reg);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_read_word   = m_word_reg;
    assign m_entry_count = m_count_reg;

endmodule
`default_nettype wire

>>> rtl/indexed_array_insert_get.sv
// Channel   Direction  Handshake           Payload
// s_        in         s_valid / s_ready   s_action, s_position, s_value
// m_        out        m_valid / m_ready   m_status, m_read_word, m_entry_count
//
// One transaction at a time. A push or any error passes through check and finish,
// a get through check, read and finish, an insert through check, shift, insert-write
// and finish: the shift walks the single-port-write entry RAM one entry per cycle,
// top down. The result is registered as the block leaves its finish state.
// Synchronous active-low reset clears the count and control; RAM is not cleared.
// A result waiting on m_ready holds the block in its final state until taken.
`default_nettype none
module indexed_array_insert_get import iaig_pkg::*; (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic [1:0]               s_action,
    input  wire logic [POS_W-1:0]         s_position,
    input  wire logic signed [WORD_W-1:0] s_value,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic [1:0]                    m_status,
    output logic signed [WORD_W-1:0]      m_read_word,
    output logic [ECNT_W-1:0]             m_entry_count
);

    mem_req_t          mem_req;
    logic [WORD_W-1:0] mem_rdata;

    iaig_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_position    (s_position),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_read_word   (m_read_word),
        .m_entry_count (m_entry_count),
        .mem_req       (mem_req),
        .mem_rdata     (mem_rdata)
    );

    iaig_ram #(
        .WIDTH (WORD_W),
        .WORDS (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .raddr (mem_req.raddr),
        .rdata (mem_rdata)
    );

    a_err_zero_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != STAT_OK) |-> (m_read_word == '0))
        else $error("error result carries nonzero word");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == STAT_FULL) |-> (m_entry_count == ECNT_W'(DEPTH)))
        else $error("full status with count below depth");

    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_req.we |-> !s_ready)
        else $error("RAM write while accepting input");

    a_count_stable_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_entry_count) && $stable(m_read_word))
        else $error("pending result changed");

endmodule
`default_nettype wire
